@@ hw/rtl/stl_pkg.sv @@
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants for the source tokenizer
// Token kinds, scan modes, keyword progress codes, byte classes and the
// token record that travels from the scanner to the output queue.
// ----------------------------------------------------------------------------
package stl_pkg;

	// counter widths
	localparam int OFFSET_BITS = 32;
	localparam int LINE_BITS   = 24;

	// widths of the token fields at the ports
	localparam int START_W = 32;
	localparam int LEN_W   = 32;
	localparam int LINE_W  = 24;

	// zero-extended widths used to take the low bits of a counter
	localparam int OFF_EXT  = (OFFSET_BITS > START_W) ? OFFSET_BITS : START_W;
	localparam int LINE_EXT = (LINE_BITS > LINE_W) ? LINE_BITS : LINE_W;

	// output queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// ASCII codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_E  = 8'h65;
	localparam logic [7:0] CH_LC_L  = 8'h6C;
	localparam logic [7:0] CH_LC_T  = 8'h74;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;

	typedef enum logic [3:0] {
		KIND_EOF   = 4'd0,
		KIND_IDENT = 4'd1,
		KIND_LET   = 4'd2,
		KIND_NUM   = 4'd3,
		KIND_PLUS  = 4'd4,
		KIND_EQUAL = 4'd5,
		KIND_SEMI  = 4'd6,
		KIND_LPAR  = 4'd7,
		KIND_RPAR  = 4'd8,
		KIND_MINUS = 4'd9,
		KIND_STAR  = 4'd10,
		KIND_SLASH = 4'd11,
		KIND_ERROR = 4'd12
	} tok_kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_IDENT  = 2'd1,
		MODE_NUMBER = 2'd2
	} scan_mode_t;

	typedef enum logic [2:0] {
		KW_NONE = 3'd0,
		KW_L    = 3'd1,
		KW_LE   = 3'd2,
		KW_LET  = 3'd3,
		KW_MISS = 3'd4
	} kw_prog_t;

	// class of one source byte
	typedef struct packed {
		logic      is_letter;
		logic      is_digit;
		logic      is_ws;
		logic      is_lf;
		logic      is_nul;
		logic      is_l;
		logic      is_e;
		logic      is_t;
		tok_kind_t op_kind;
	} byte_class_t;

	// one token as delivered
	typedef struct packed {
		tok_kind_t           kind;
		logic [START_W-1:0]  start;
		logic [LEN_W-1:0]    length;
		logic [LINE_W-1:0]   line;
		logic                last;
	} token_t;

	// low bits of an offset, zero-extended when the counter is narrow
	function automatic logic [START_W-1:0] off_low(input logic [OFFSET_BITS-1:0] x);
		logic [OFF_EXT-1:0] w;
		w = OFF_EXT'(x);
		return w[START_W-1:0];
	endfunction

	// low bits of the line counter
	function automatic logic [LINE_W-1:0] line_low(input logic [LINE_BITS-1:0] x);
		logic [LINE_EXT-1:0] w;
		w = LINE_EXT'(x);
		return w[LINE_W-1:0];
	endfunction

endpackage

@@ hw/rtl/stl_classify.sv @@
// ----------------------------------------------------------------------------
// stl_classify: byte classifier
// Sorts one source byte into letter, digit, blank, newline, end of source,
// and gives the operator or error kind for everything else.
// ----------------------------------------------------------------------------
module stl_classify (
	input  logic [7:0]          src,
	output stl_pkg::byte_class_t cls
);
	import stl_pkg::*;

	always_comb begin
		cls.is_letter = ((src >= CH_LC_A) && (src <= CH_LC_Z)) ||
		                ((src >= CH_UC_A) && (src <= CH_UC_Z)) || (src == CH_UNDER);
		cls.is_digit  = (src >= CH_0) && (src <= CH_9);
		cls.is_ws     = (src == CH_SPACE) || (src == CH_TAB) || (src == CH_CR);
		cls.is_lf     = (src == CH_LF);
		cls.is_nul    = (src == CH_NUL);
		cls.is_l      = (src == CH_LC_L);
		cls.is_e      = (src == CH_LC_E);
		cls.is_t      = (src == CH_LC_T);

		// single-character operators; anything unknown is an error
		case (src)
			CH_PLUS:  cls.op_kind = KIND_PLUS;
			CH_EQUAL: cls.op_kind = KIND_EQUAL;
			CH_SEMI:  cls.op_kind = KIND_SEMI;
			CH_LPAR:  cls.op_kind = KIND_LPAR;
			CH_RPAR:  cls.op_kind = KIND_RPAR;
			CH_MINUS: cls.op_kind = KIND_MINUS;
			CH_STAR:  cls.op_kind = KIND_STAR;
			CH_SLASH: cls.op_kind = KIND_SLASH;
			default:  cls.op_kind = KIND_ERROR;
		endcase
	end

endmodule

@@ hw/rtl/stl_scan.sv @@
// ----------------------------------------------------------------------------
// stl_scan: scanner state and token builder
// Holds mode, offsets, line count and keyword progress. For each byte taken
// it closes an open identifier or number, then scans the byte itself,
// giving up to two tokens in the same cycle.
// ----------------------------------------------------------------------------
module stl_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  stl_pkg::byte_class_t cls,
	output stl_pkg::token_t      tok_a,
	output stl_pkg::token_t      tok_b,
	output logic [1:0]           tok_n
);
	import stl_pkg::*;

	localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
	localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
	localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);

	scan_mode_t             mode_q, mode_d;
	kw_prog_t               kp_q, kp_d;
	logic [OFFSET_BITS-1:0] off_q, off_d, start_q, start_d, off_inc;
	logic [LINE_BITS-1:0]   line_q, line_d;

	logic      pre_vld, new_vld, scan_byte;
	tok_kind_t pre_kind;
	token_t    pre_tok, new_tok;

	// saturating offset step
	assign off_inc = (off_q == OFF_MAX) ? off_q : off_q + OFFSET_BITS'(1);

	// next state and tokens
	always_comb begin
		mode_d    = mode_q;
		kp_d      = kp_q;
		off_d     = off_q;
		start_d   = start_q;
		line_d    = line_q;
		pre_vld   = 1'b0;
		pre_kind  = KIND_IDENT;
		scan_byte = 1'b1;
		new_vld   = 1'b0;
		new_tok   = '0;

		// continue or close the open token
		case (mode_q)
			MODE_IDENT: begin
				if (cls.is_letter || cls.is_digit) begin
					if (kp_q == KW_L && cls.is_e)
						kp_d = KW_LE;
					else if (kp_q == KW_LE && cls.is_t)
						kp_d = KW_LET;
					else
						kp_d = KW_MISS;
					off_d     = off_inc;
					scan_byte = 1'b0;
				end else begin
					pre_vld  = 1'b1;
					pre_kind = (kp_q == KW_LET) ? KIND_LET : KIND_IDENT;
					mode_d   = MODE_IDLE;
					kp_d     = KW_NONE;
				end
			end
			MODE_NUMBER: begin
				if (cls.is_digit) begin
					off_d     = off_inc;
					scan_byte = 1'b0;
				end else begin
					pre_vld  = 1'b1;
					pre_kind = KIND_NUM;
					mode_d   = MODE_IDLE;
				end
			end
			default: ;
		endcase

		pre_tok.kind   = pre_kind;
		pre_tok.start  = off_low(start_q);
		pre_tok.length = off_low(off_q - start_q);
		pre_tok.line   = line_low(line_q);
		pre_tok.last   = 1'b0;

		// scan the byte as the start of a new token
		if (scan_byte) begin
			if (cls.is_ws) begin
				off_d = off_inc;
			end else if (cls.is_lf) begin
				line_d = (line_q == LINE_MAX) ? line_q : line_q + LINE_ONE;
				off_d  = off_inc;
			end else if (cls.is_nul) begin
				new_vld        = 1'b1;
				new_tok.kind   = KIND_EOF;
				new_tok.start  = off_low(off_q);
				new_tok.length = '0;
				new_tok.line   = line_low(line_q);
				// end of source: back to reset values
				mode_d  = MODE_IDLE;
				kp_d    = KW_NONE;
				off_d   = '0;
				start_d = '0;
				line_d  = LINE_ONE;
			end else if (cls.is_letter) begin
				start_d = off_q;
				kp_d    = cls.is_l ? KW_L : KW_MISS;
				mode_d  = MODE_IDENT;
				off_d   = off_inc;
			end else if (cls.is_digit) begin
				start_d = off_q;
				mode_d  = MODE_NUMBER;
				off_d   = off_inc;
			end else begin
				new_vld        = 1'b1;
				new_tok.kind   = cls.op_kind;
				new_tok.start  = off_low(off_q);
				new_tok.length = LEN_W'(1);
				new_tok.line   = line_low(line_q);
				start_d        = off_q;
				off_d          = off_inc;
			end
		end
		new_tok.last = 1'b1;
	end

	// pack tokens in order, last flag on the final one
	always_comb begin
		tok_a = pre_vld ? pre_tok : new_tok;
		tok_b = new_tok;
		tok_a.last = !(pre_vld && new_vld);
		tok_n = {1'b0, pre_vld} + {1'b0, new_vld};
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			kp_q    <= KW_NONE;
			off_q   <= '0;
			start_q <= '0;
			line_q  <= LINE_ONE;
		end else if (en) begin
			mode_q  <= mode_d;
			kp_q    <= kp_d;
			off_q   <= off_d;
			start_q <= start_d;
			line_q  <= line_d;
		end
	end

endmodule

@@ hw/rtl/stl_tok_fifo.sv @@
// ----------------------------------------------------------------------------
// stl_tok_fifo: token output queue
// Small register queue that takes up to two tokens per cycle and hands out
// one per cycle from its head entry.
// ----------------------------------------------------------------------------
module stl_tok_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    push_n,
	input  stl_pkg::token_t               push_a,
	input  stl_pkg::token_t               push_b,
	input  logic                          pop,
	output stl_pkg::token_t               head,
	output logic [stl_pkg::FIFO_CNT_W-1:0] count
);
	import stl_pkg::*;

	token_t                entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q, rd_q, wr_nx;
	logic [FIFO_CNT_W-1:0] count_q;

	assign wr_nx = wr_q + FIFO_PTR_W'(1);
	assign head  = entry_q[rd_q];
	assign count = count_q;

	// storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < FIFO_DEPTH; i++) begin
			if (push_n != 2'd0 && wr_q == FIFO_PTR_W'(i))
				entry_q[i] <= push_a;
			else if (push_n == 2'd2 && wr_nx == FIFO_PTR_W'(i))
				entry_q[i] <= push_b;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + FIFO_PTR_W'(push_n);
			if (pop)
				rd_q <= rd_q + FIFO_PTR_W'(1);
			count_q <= count_q + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
		end
	end

endmodule

@@ hw/rtl/source_tokenizer.sv @@
// ----------------------------------------------------------------------------
// source_tokenizer: byte-serial lexical scanner
// Turns a stream of ASCII source bytes into identifier, keyword, number,
// operator, error and end-of-source tokens with offset, length and line.
// ----------------------------------------------------------------------------
//
//  channel  | signals                               | role
//  ---------+---------------------------------------+--------------------------
//  source   | src_valid, src_ready, source_byte     | one source byte per transfer
//  token    | tok_valid, tok_ready, token_kind,     | one token per transfer
//           | token_start, token_length,            |
//           | token_line, last_of_run               |
//
//  A byte goes from the input register to the scanner; one byte per cycle is
//  sustained while each byte gives at most one token and tok_ready is high. A
//  byte that closes an identifier or number and is itself an operator, error or
//  end of source gives two tokens, which drain from the four-entry output queue
//  at one per cycle while tok_ready is high. The scanner takes a byte only while
//  the queue holds two tokens or fewer. Reset empties the input register and
//  queue and puts the scanner at offset 0, line 1. Output stalls back up through
//  the queue to src_ready; there is no combinational path between them.
module source_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_ready,
	input  logic [7:0]  source_byte,
	output logic        tok_valid,
	input  logic        tok_ready,
	output logic [3:0]  token_kind,
	output logic [31:0] token_start,
	output logic [31:0] token_length,
	output logic [23:0] token_line,
	output logic        last_of_run
);
	import stl_pkg::*;

	localparam logic [FIFO_CNT_W-1:0] ROOM_MAX = FIFO_CNT_W'(FIFO_DEPTH - 2);

	logic                  valid_s1, consume, pop;
	logic [7:0]            byte_s1;
	byte_class_t           cls;
	token_t                tok_a, tok_b, head;
	logic [1:0]            tok_n, push_n;
	logic [FIFO_CNT_W-1:0] count;

	// scanner takes the held byte when the queue has room for two tokens
	assign consume   = valid_s1 && (count <= ROOM_MAX);
	assign src_ready = !valid_s1 || consume;
	assign push_n    = consume ? tok_n : 2'd0;
	assign pop       = tok_valid && tok_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (src_ready)
			valid_s1 <= src_valid;
	end

	always_ff @(posedge clk) begin
		if (src_valid && src_ready)
			byte_s1 <= source_byte;
	end

	stl_classify u_classify (
		.src (byte_s1),
		.cls (cls)
	);

	stl_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (consume),
		.cls    (cls),
		.tok_a  (tok_a),
		.tok_b  (tok_b),
		.tok_n  (tok_n)
	);

	stl_tok_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push_n (push_n),
		.push_a (tok_a),
		.push_b (tok_b),
		.pop    (pop),
		.head   (head),
		.count  (count)
	);

	// token outputs
	assign tok_valid    = (count != '0);
	assign token_kind   = head.kind;
	assign token_start  = head.start;
	assign token_length = head.length;
	assign token_line   = head.line;
	assign last_of_run  = head.last;

	// queue never overfills
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("token queue over its depth");

	// a byte is only scanned with room for two tokens
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		consume |-> (count + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop))
			<= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("scan without room in token queue");

	// an accepted byte is held for the scanner next cycle
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(src_valid && src_ready) |=> valid_s1)
		else $error("accepted byte lost from input register");

	// pushing two tokens only happens with the first not marked last
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n == 2'd2) |-> (!tok_a.last && tok_b.last))
		else $error("token pair with wrong last flags");

endmodule
